// File: sv/gpos_class_pair_kerning_lookup_macros.svh
// Assertion macros shared by the checker
`ifndef GPOS_CLASS_PAIR_KERNING_LOOKUP_MACROS_SVH
`define GPOS_CLASS_PAIR_KERNING_LOOKUP_MACROS_SVH
// assertion that A implies B on the same edge
`define GCK_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// assertion that A implies B on the next edge
`define GCK_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

// File: sv/gck_pkg.sv
// ---------------------------------------------------------------------
// gck_pkg
// Types and constants for the class-pair kerning lookup.
// ---------------------------------------------------------------------
`timescale 1ns / 1ps
package gck_pkg;
	localparam logic [1:0] ST_FOUND   = 2'd0;
	localparam logic [1:0] ST_NONE    = 2'd1;
	localparam logic [1:0] ST_VERSION = 2'd2;
	localparam logic       CMD_LOAD   = 1'b0;
	localparam logic       CMD_QUERY  = 1'b1;
	localparam logic [15:0] PAIR_POS_TYPE     = 16'd2;
	localparam logic [15:0] CLASS_PAIR_FORMAT = 16'd2;
	localparam logic [15:0] VF_XADVANCE       = 16'd4;

	typedef struct packed {
		logic        cmd;
		logic [15:0] byte_address;
		logic [7:0]  byte_value;
		logic [15:0] left_glyph;
		logic [15:0] right_glyph;
	} gck_in_t;

	typedef struct packed {
		logic signed [15:0] advance_adjust;
		logic [1:0]         status;
	} gck_out_t;
endpackage

// File: sv/gpos_class_pair_kerning_lookup.sv
// ---------------------------------------------------------------------
// gpos_class_pair_kerning_lookup
// Loads a positioning table into byte memory and answers class-pair
// x-advance kerning queries by walking the table.
// ---------------------------------------------------------------------
// channel   ports                      handshake
// item in   start, busy, item          start & !busy
// result    result_valid, result       strobe, one cycle
//
// A load writes one byte and leaves busy low. A query walks the table through
// one byte read port, two byte reads per 16-bit word. A bad version answers
// after the version words; each extra lookup, subtable and class range
// walked lengthens the query.
// Reset clears control only; table contents are undefined until written.
// The receiver cannot stall; busy holds off new items during a query.
`timescale 1ns / 1ps
module gpos_class_pair_kerning_lookup #(
	parameter int TABLE_BYTES = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gck_pkg::gck_in_t  item,
	output logic              result_valid,
	output gck_pkg::gck_out_t result
);
	import gck_pkg::*;

	localparam int AW = $clog2(TABLE_BYTES);

	typedef enum logic [4:0] {
		S_IDLE, S_VER0, S_VER1, S_LL, S_NLOOK, S_LOFF, S_LTYPE, S_NSUB,
		S_SOFF, S_SFMT, S_VF1, S_VF2, S_CD1, S_CD2, S_N1, S_N2,
		S_CFMT, S_CF1A, S_CF1B, S_CF1C, S_CRN, S_CRLO, S_CRHI, S_CRCL,
		S_MUL, S_VAL, S_DONE
	} state_t;

	state_t      state_q, ret_q;
	logic [15:0] g1_q, g2_q;
	logic [AW-1:0] addr_q, llist_q, look_q, sub_q, cbase_q, rec_q, cd2_q;
	logic [15:0] nlook_q, li_q, nsub_q, si_q, cnt_q, ri_q, lo_q, st_q;
	logic [15:0] c1_q, c2_q, n1_q, n2_q, w;
	logic        side_q, ok1_q, ok2_q;
	logic [31:0] prod;
	logic [7:0]  hi_q, rdata;
	logic        phase_q, wdone;
	logic [1:0]  bcnt_q;
	logic [AW-1:0] raddr;
	logic        we;

	// word read sequencer: phase 0 issue, phase 1 capture; two bytes
	assign raddr = addr_q + AW'(bcnt_q[0]);
	assign w     = {hi_q, rdata};
	assign wdone = phase_q && bcnt_q[0];
	assign we    = start && !busy && item.cmd == CMD_LOAD;
	assign prod  = c1_q * n2_q;

	gck_mem #(.AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(AW'(item.byte_address)),
		.wdata(item.byte_value), .raddr(raddr), .rdata(rdata)
	);

	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			phase_q <= 1'b0;
			bcnt_q <= 2'd0;
			result_valid <= 1'b0;
			result <= '0;
		end else begin
			result_valid <= 1'b0;
			if (state_q != S_IDLE && state_q != S_MUL && state_q != S_DONE) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					if (!bcnt_q[0]) hi_q <= rdata;
					bcnt_q[0] <= !bcnt_q[0];
				end
			end
			case (state_q)
				S_IDLE: if (start && item.cmd == CMD_QUERY) begin
					g1_q <= item.left_glyph;
					g2_q <= item.right_glyph;
					addr_q <= '0;
					phase_q <= 1'b0;
					bcnt_q <= 2'd0;
					state_q <= S_VER0;
				end
				S_VER0: if (wdone) begin
					if (w != 16'd1) begin
						st_q <= 16'(ST_VERSION);
						state_q <= S_DONE;
					end else begin
						addr_q <= AW'(2);
						state_q <= S_VER1;
					end
				end
				S_VER1: if (wdone) begin
					if (w != 16'd0) begin
						st_q <= 16'(ST_VERSION);
						state_q <= S_DONE;
					end else begin
						addr_q <= AW'(8);
						state_q <= S_LL;
					end
				end
				S_LL: if (wdone) begin
					llist_q <= AW'(w);
					addr_q <= AW'(w);
					state_q <= S_NLOOK;
				end
				S_NLOOK: if (wdone) begin
					nlook_q <= w;
					li_q <= '0;
					st_q <= 16'(ST_NONE);
					if (w == 16'd0) state_q <= S_DONE;
					else begin
						addr_q <= llist_q + AW'(2);
						state_q <= S_LOFF;
					end
				end
				S_LOFF: if (wdone) begin
					look_q <= llist_q + AW'(w);
					addr_q <= llist_q + AW'(w);
					state_q <= S_LTYPE;
				end
				S_LTYPE: if (wdone) begin
					if (w != PAIR_POS_TYPE) begin
						if (li_q + 16'd1 >= nlook_q) state_q <= S_DONE;
						else begin
							li_q <= li_q + 16'd1;
							addr_q <= llist_q + AW'({li_q + 16'd1, 1'b0}) + AW'(2);
							state_q <= S_LOFF;
						end
					end else begin
						addr_q <= look_q + AW'(4);
						state_q <= S_NSUB;
					end
				end
				S_NSUB: if (wdone) begin
					nsub_q <= w;
					si_q <= '0;
					if (w == 16'd0) begin
						if (li_q + 16'd1 >= nlook_q) state_q <= S_DONE;
						else begin
							li_q <= li_q + 16'd1;
							addr_q <= llist_q + AW'({li_q + 16'd1, 1'b0}) + AW'(2);
							state_q <= S_LOFF;
						end
					end else begin
						addr_q <= look_q + AW'(6);
						state_q <= S_SOFF;
					end
				end
				S_SOFF: if (wdone) begin
					sub_q <= look_q + AW'(w);
					addr_q <= look_q + AW'(w);
					state_q <= S_SFMT;
				end
				S_SFMT, S_VF1, S_VF2: if (wdone) begin
					if ((state_q == S_SFMT && w != CLASS_PAIR_FORMAT) ||
					    (state_q == S_VF1 && w != VF_XADVANCE) ||
					    (state_q == S_VF2 && w != 16'd0)) begin
						// next subtable, else next lookup, else done
						if (si_q + 16'd1 < nsub_q) begin
							si_q <= si_q + 16'd1;
							addr_q <= look_q + AW'({si_q + 16'd1, 1'b0}) + AW'(6);
							state_q <= S_SOFF;
						end else if (li_q + 16'd1 >= nlook_q) state_q <= S_DONE;
						else begin
							li_q <= li_q + 16'd1;
							addr_q <= llist_q + AW'({li_q + 16'd1, 1'b0}) + AW'(2);
							state_q <= S_LOFF;
						end
					end else if (state_q == S_SFMT) begin
						addr_q <= sub_q + AW'(4);
						state_q <= S_VF1;
					end else if (state_q == S_VF1) begin
						addr_q <= sub_q + AW'(6);
						state_q <= S_VF2;
					end else begin
						addr_q <= sub_q + AW'(8);
						state_q <= S_CD1;
					end
				end
				S_CD1: if (wdone) begin
					cbase_q <= sub_q + AW'(w);
					addr_q <= sub_q + AW'(10);
					state_q <= S_CD2;
				end
				S_CD2: if (wdone) begin
					cd2_q <= sub_q + AW'(w);
					addr_q <= sub_q + AW'(12);
					state_q <= S_N1;
				end
				S_N1: if (wdone) begin
					n1_q <= w;
					addr_q <= sub_q + AW'(14);
					state_q <= S_N2;
				end
				S_N2: if (wdone) begin
					n2_q <= w;
					side_q <= 1'b0;
					ok1_q <= 1'b0;
					ok2_q <= 1'b0;
					c1_q <= '0;
					c2_q <= '0;
					addr_q <= cbase_q;
					state_q <= S_CFMT;
				end
				S_CFMT: if (wdone) begin
					if (w == 16'd1) begin
						addr_q <= cbase_q + AW'(2);
						state_q <= S_CF1A;
					end else if (w == 16'd2) begin
						addr_q <= cbase_q + AW'(2);
						state_q <= S_CRN;
					end else state_q <= ret_q;
				end
				S_CF1A: if (wdone) begin
					lo_q <= w;
					addr_q <= cbase_q + AW'(4);
					state_q <= S_CF1B;
				end
				S_CF1B: if (wdone) begin
					if ((side_q ? g2_q : g1_q) >= lo_q &&
					    {1'b0, side_q ? g2_q : g1_q} < {1'b0, lo_q} + {1'b0, w}) begin
						addr_q <= cbase_q + AW'(6) +
							AW'({(side_q ? g2_q : g1_q) - lo_q, 1'b0});
						state_q <= S_CF1C;
					end else state_q <= ret_q;
				end
				S_CF1C, S_CRCL: if (wdone) begin
					if (side_q) begin c2_q <= w; ok2_q <= 1'b1; end
					else begin c1_q <= w; ok1_q <= 1'b1; end
					state_q <= ret_q;
				end
				S_CRN: if (wdone) begin
					cnt_q <= w;
					ri_q <= '0;
					rec_q <= cbase_q + AW'(4);
					addr_q <= cbase_q + AW'(4);
					if (w == 16'd0) state_q <= ret_q;
					else state_q <= S_CRLO;
				end
				S_CRLO: if (wdone) begin
					lo_q <= w;
					addr_q <= rec_q + AW'(2);
					state_q <= S_CRHI;
				end
				S_CRHI: if (wdone) begin
					if (lo_q <= (side_q ? g2_q : g1_q) && (side_q ? g2_q : g1_q) <= w) begin
						addr_q <= rec_q + AW'(4);
						state_q <= S_CRCL;
					end else if (ri_q + 16'd1 >= cnt_q) state_q <= ret_q;
					else begin
						ri_q <= ri_q + 16'd1;
						rec_q <= rec_q + AW'(6);
						addr_q <= rec_q + AW'(6);
						state_q <= S_CRLO;
					end
				end
				S_MUL: begin
					// entered via ret_q after each class walk
					if (!side_q) begin
						side_q <= 1'b1;
						cbase_q <= cd2_q;
						addr_q <= cd2_q;
						phase_q <= 1'b0;
						bcnt_q <= 2'd0;
						state_q <= S_CFMT;
					end else if (!ok1_q || c1_q >= n1_q || !ok2_q || c2_q >= n2_q) begin
						st_q <= 16'(ST_NONE);
						state_q <= S_DONE;
					end else begin
						phase_q <= 1'b0;
						bcnt_q <= 2'd0;
						state_q <= S_VAL;
						addr_q <= sub_q + AW'(16) + AW'({prod, 1'b0}) + AW'({c2_q, 1'b0});
					end
				end
				S_VAL: if (wdone) begin
					result.advance_adjust <= w;
					st_q <= 16'(ST_FOUND);
					state_q <= S_DONE;
				end
				S_DONE: begin
					result_valid <= 1'b1;
					result.status <= st_q[1:0];
					if (st_q[1:0] != ST_FOUND) result.advance_adjust <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_N2 && wdone) ret_q <= S_MUL;
		end
	end
endmodule

// File: sv/gck_mem.sv
// ---------------------------------------------------------------------
// gck_mem
// Byte-wide table store, one write port, one registered read port.
// ---------------------------------------------------------------------
`timescale 1ns / 1ps
module gck_mem #(
	parameter int AW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: sv/gck_checker.sv
// ---------------------------------------------------------------------
// gck_checker
// Port-level checks for the kerning lookup.
// ---------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gpos_class_pair_kerning_lookup_macros.svh"
module gck_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input gck_pkg::gck_in_t  item,
	input logic              result_valid,
	input gck_pkg::gck_out_t result
);
	import gck_pkg::*;

	`GCK_ASSERT_NEXT(a_load_no_busy, clk, arst_n, start && !busy && item.cmd == CMD_LOAD, !busy)
	`GCK_ASSERT_NEXT(a_query_busy, clk, arst_n, start && !busy && item.cmd == CMD_QUERY, busy)
	`GCK_ASSERT_IMP(a_status_range, clk, arst_n, result_valid, result.status != 2'd3)
	`GCK_ASSERT_IMP(a_zero_adj, clk, arst_n, result_valid && result.status != ST_FOUND,
		result.advance_adjust == 16'sd0)
	`GCK_ASSERT_NEXT(a_one_strobe, clk, arst_n, result_valid, !result_valid)
endmodule

bind gpos_class_pair_kerning_lookup gck_checker u_gck_checker (.*);
